>>> hw/rtl/iil_pkg.sv
// iil_pkg: shared types and constants for the indexed insert list unit
// holds the request/response word structs, action and status codes, and the cell control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iil_pkg;

	// default sizes
	localparam int CAPACITY_DEF      = 64;
	localparam int ELEMENT_WIDTH_DEF = 32;

	// fixed field widths of the request and response words
	localparam int ACT_W   = 2;
	localparam int IDX_W   = 6;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 7;

	// cells per group in the read-out tree
	localparam int GROUP_SIZE = 8;

	// action codes
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic [VAL_W-1:0]  read_value;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
	} rsp_word_t;

	// control broadcast to every cell
	typedef struct packed {
		logic             ins_en;
		logic [IDX_W-1:0] index;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/indexed_insert_list_unit.sv
// indexed_insert_list_unit: fixed-capacity ordered list built as a row of element cells
// depends on iil_pkg and iil_cell
// a word's response is registered in stage 1, then in the response register
// one word per cycle when not stalled; an insert shifts all later cells on accept
// read-out goes through a registered group-OR stage, then a group select into the response
// reset clears the length and the pipeline valids; cell contents are left as they are
`timescale 1ns / 1ps
`default_nettype none

module indexed_insert_list_unit #(
	parameter int CAPACITY      = iil_pkg::CAPACITY_DEF,
	parameter int ELEMENT_WIDTH = iil_pkg::ELEMENT_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire iil_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output iil_pkg::rsp_word_t      rsp
);
	import iil_pkg::*;

	localparam int LEN_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (LEN_W > IDX_W) ? LEN_W : IDX_W;
	localparam int NGRP_A = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int NGRP_I = (1 << IDX_W) / GROUP_SIZE;
	localparam int NGRP   = (NGRP_A < NGRP_I) ? NGRP_A : NGRP_I;
	localparam int GRP_W  = IDX_W - $clog2(GROUP_SIZE);
	localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         len_nxt;
	logic                     accept;
	logic                     s1_adv;
	logic [CMP_W-1:0]         idx_ext;
	logic [CMP_W-1:0]         len_ext;
	logic                     ins_ok;
	logic                     rd_ok;
	logic [STAT_W-1:0]        status_nxt;
	cell_ctrl_t               ctrl;
	logic [ELEMENT_WIDTH-1:0] ins_value;

	logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] grp_or    [NGRP];

	logic                     s1_valid_q;
	logic [STAT_W-1:0]        status_s1;
	logic [LEN_W-1:0]         count_s1;
	logic                     rd_ok_s1;
	logic [GRP_W-1:0]         grp_s1;
	logic [ELEMENT_WIDTH-1:0] grp_or_s1 [NGRP];
	logic [ELEMENT_WIDTH-1:0] rd_sel;

	logic                     rsp_valid_q;
	rsp_word_t                rsp_q;

	// handshake: stage 1 moves on whenever the response register is empty or being taken
	assign s1_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = s1_valid_q && !s1_adv;
	assign accept    = req_valid && !req_stall;

	// range and capacity checks
	assign idx_ext = CMP_W'(req.index);
	assign len_ext = CMP_W'(len_q);
	assign rd_ok   = (req.action == ACT_READ) && (idx_ext < len_ext);
	assign ins_ok  = (req.action == ACT_INSERT) && (idx_ext <= len_ext) && (len_q < CAP_L);

	always_comb begin
		status_nxt = ST_OK;
		len_nxt    = len_q;
		case (req.action)
			ACT_READ: begin
				if (!rd_ok) status_nxt = ST_RANGE;
			end
			ACT_INSERT: begin
				if (idx_ext > len_ext) begin
					status_nxt = ST_RANGE;
				end else if (len_q >= CAP_L) begin
					status_nxt = ST_FULL;
				end else begin
					len_nxt = len_q + 1'b1;
				end
			end
			ACT_CLEAR: begin
				len_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	// list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept) begin
			len_q <= len_nxt;
		end
	end

	// cell row
	assign ctrl.ins_en = accept && ins_ok;
	assign ctrl.index  = req.index;
	assign ins_value   = ELEMENT_WIDTH'(req.value);

	for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
		logic [ELEMENT_WIDTH-1:0] left;
		if (c == 0) begin : g_first
			assign left = '0;
		end else begin : g_rest
			assign left = cell_data[c-1];
		end
		iil_cell #(
			.POS           (c),
			.ELEMENT_WIDTH (ELEMENT_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.ins_value (ins_value),
			.left_data (left),
			.data      (cell_data[c]),
			.rd_data   (cell_rd[c])
		);
	end

	// group-wise OR of the cell read-outs
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < CAPACITY) begin
					grp_or[g] = grp_or[g] | cell_rd[g * GROUP_SIZE + k];
				end
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_nxt;
			count_s1  <= len_nxt;
			rd_ok_s1  <= rd_ok;
			grp_s1    <= req.index[IDX_W-1:IDX_W-GRP_W];
			for (int g = 0; g < NGRP; g++) begin
				grp_or_s1[g] <= grp_or[g];
			end
		end
	end

	// group select
	always_comb begin
		rd_sel = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (grp_s1 == GRP_W'(g)) rd_sel = rd_sel | grp_or_s1[g];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			rsp_q.read_value <= rd_ok_s1 ? VAL_W'(rd_sel) : '0;
			rsp_q.status     <= status_s1;
			rsp_q.count      <= CNT_W'(count_s1);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CAP_L)
		else $error("list length beyond capacity");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ins_ok |=> len_q == $past(len_q) + 1'b1)
		else $error("accepted insert did not grow the list");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.action == ACT_CLEAR |=> len_q == '0)
		else $error("clear left a nonzero length");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_adv |=> rsp_valid_q)
		else $error("stage 1 word lost on the way to the response");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ST_OK |-> rsp_q.read_value == '0)
		else $error("error response carries read data");

endmodule

`default_nettype wire

>>> hw/rtl/iil_cell.sv
// iil_cell: one list position; holds one element and takes its left neighbor on insert
// depends on iil_pkg for the cell control struct
`timescale 1ns / 1ps
`default_nettype none

module iil_cell #(
	parameter int POS           = 0,
	parameter int ELEMENT_WIDTH = iil_pkg::ELEMENT_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire iil_pkg::cell_ctrl_t      ctrl,
	input  wire logic [ELEMENT_WIDTH-1:0] ins_value,
	input  wire logic [ELEMENT_WIDTH-1:0] left_data,
	output logic      [ELEMENT_WIDTH-1:0] data,
	output logic      [ELEMENT_WIDTH-1:0] rd_data
);
	import iil_pkg::*;

	// position clamped to 64 so it compares against the 6-bit index; beyond that it is always after
	localparam logic [IDX_W:0] POS_C = (POS > 64) ? 7'd64 : (IDX_W + 1)'(POS);

	logic [ELEMENT_WIDTH-1:0] data_q;
	logic                     hit;
	logic                     after;

	assign hit   = (POS_C == {1'b0, ctrl.index});
	assign after = (POS_C > {1'b0, ctrl.index});

	// insert: shift up above the index, load the new word at the index
	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (after) begin
				data_q <= left_data;
			end else if (hit) begin
				data_q <= ins_value;
			end
		end
	end

	assign data    = data_q;
	assign rd_data = hit ? data_q : '0;

endmodule

`default_nettype wire
